// ===== hdl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helpers of the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int MaxResults = 4;
  localparam int HeldConts  = 3;

  localparam logic [20:0] CpMin2   = 21'h000080;
  localparam logic [20:0] CpMin3   = 21'h000800;
  localparam logic [20:0] CpSurLo  = 21'h00D800;
  localparam logic [20:0] CpSurHi  = 21'h00DFFF;
  localparam logic [20:0] CpMin4   = 21'h010000;
  localparam logic [20:0] CpMax    = 21'h10FFFF;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  bytes_used;
  } result_t;

  typedef struct packed {
    logic [7:0]                 lead;
    logic [HeldConts-1:0][7:0]  cont;
    logic [1:0]                 count;
    logic                       pending;
  } dec_state_t;

  typedef struct packed {
    dec_state_t                   nxt;
    result_t [MaxResults-1:0]     res;
    logic [2:0]                   n;
  } dec_out_t;

  // continuation bytes a lead byte asks for, zero when it is no multi-byte lead
  function automatic logic [1:0] need_cont(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b[7:5] == 3'b110) r = 2'd1;
    else if (b[7:4] == 4'b1110) r = 2'd2;
    else if (b[7:3] == 5'b11110) r = 2'd3;
    return r;
  endfunction

  function automatic result_t mk_result(input logic [20:0] cp, input logic err,
                                        input logic [2:0] used);
    result_t r;
    r.code_point = cp;
    r.is_error   = err;
    r.bytes_used = used;
    return r;
  endfunction

  function automatic result_t mk_error(input logic [7:0] b);
    return mk_result({13'd0, b}, 1'b1, 3'd1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Validating UTF-8 decoder, one byte in per request, code points out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the result buffer keeps pace. A byte is
// held in the input register, is decoded in a single pass against the held
// sequence, and its results are loaded into a four-entry result buffer that
// drains one result per cycle while the receiver is ready. Most bytes give
// zero or one result, so the stream runs at one byte per cycle when the
// receiver does not stall; a byte that gives more than one result (an error
// run, up to four) holds the input while the buffer drains. Errors carry the
// rejected byte with bytes_used of one; tlast marks the last result of a byte
// and tuser bit one the last result of a byte that arrived with tlast set.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // code_point[20:0], bytes_used[23:21]
  output logic        m_axis_tlast,   // run_end
  output logic [1:0]  m_axis_tuser    // is_error[0], stream_end[1]
);
  import utf8d_pkg::*;

  logic                      in_v;
  logic [7:0]                in_byte_r;
  logic                      in_eos_r;
  logic [7:0]                lead;
  logic [HeldConts-1:0][7:0] cont;
  logic [1:0]                count;
  logic                      pending;
  dec_state_t                st;
  dec_out_t                  dec;
  result_t [MaxResults-1:0]  rbuf;
  logic [2:0]                buf_cnt;
  logic [1:0]                rd;
  logic                      buf_eos;
  logic                      load;
  logic                      s_take;
  logic                      m_take;
  result_t                   cur;

  assign st.lead    = lead;
  assign st.cont    = cont;
  assign st.count   = count;
  assign st.pending = pending;

  utf8d_decode u_decode (
    .st      (st),
    .in_byte (in_byte_r),
    .eos     (in_eos_r),
    .dec     (dec)
  );

  assign m_take = m_axis_tvalid && m_axis_tready;
  assign load   = in_v && ((buf_cnt == 3'd0) || ((buf_cnt == 3'd1) && m_axis_tready));
  assign s_axis_tready = !in_v || load;
  assign s_take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_take) begin
      in_v <= 1'b1;
    end else if (load) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_byte_r <= s_axis_tdata;
      in_eos_r  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead    <= 8'd0;
      count   <= 2'd0;
      pending <= 1'b0;
    end else if (load) begin
      lead    <= dec.nxt.lead;
      count   <= dec.nxt.count;
      pending <= dec.nxt.pending;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cont    <= dec.nxt.cont;
      rbuf    <= dec.res;
      buf_eos <= in_eos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 3'd0;
      rd      <= 2'd0;
    end else if (load) begin
      buf_cnt <= dec.n;
      rd      <= 2'd0;
    end else if (m_take) begin
      buf_cnt <= buf_cnt - 3'd1;
      rd      <= rd + 2'd1;
    end
  end

  assign cur           = rbuf[rd];
  assign m_axis_tvalid = (buf_cnt != 3'd0);
  assign m_axis_tdata  = {cur.bytes_used, cur.code_point};
  assign m_axis_tlast  = (buf_cnt == 3'd1);
  assign m_axis_tuser  = {buf_eos && (buf_cnt == 3'd1), cur.is_error};

  // an open sequence never holds as many continuations as its lead asks for
  a_held_short: assert property (@(posedge clk) disable iff (rst)
    pending |-> ({1'b0, count} < {1'b0, need_cont(lead)}))
    else $error("held continuation count reached lead length");

  // a byte flagged end of stream always yields at least one result
  a_eos_result: assert property (@(posedge clk) disable iff (rst)
    (load && in_eos_r) |=> m_axis_tvalid)
    else $error("end of stream byte produced no result");

  // rejected bytes count as a single byte
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[23:21] == 3'd1))
    else $error("error result with bytes_used other than one");

  // accepted code points stay in the unicode range
  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[20:0] <= CpMax))
    else $error("decoded code point above range");

endmodule

`default_nettype wire

// ===== hdl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Combinational step: one byte against the held sequence gives the next
// sequence state and a list of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
  input  utf8d_pkg::dec_state_t st,
  input  logic [7:0]            in_byte,
  input  logic                  eos,
  output utf8d_pkg::dec_out_t   dec
);
  import utf8d_pkg::*;

  logic [1:0]                need;
  logic                      is_cont;
  logic [2:0]                cont_cnt;
  logic [HeldConts-1:0][7:0] cont_w;
  logic [20:0]               cp1;
  logic [20:0]               cp2;
  logic [20:0]               cp3;
  logic                      ok;
  logic [20:0]               cp_sel;

  assign need     = need_cont(st.lead);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign cont_cnt = {1'b0, st.count} + 3'd1;

  // held continuations with the incoming byte dropped in at the fill point
  always_comb begin
    cont_w = st.cont;
    for (int i = 0; i < HeldConts; i++) begin
      if (2'(i) == st.count) cont_w[i] = in_byte;
    end
  end

  assign cp1 = {10'd0, st.lead[4:0], cont_w[0][5:0]};
  assign cp2 = {5'd0, st.lead[3:0], cont_w[0][5:0], cont_w[1][5:0]};
  assign cp3 = {st.lead[2:0], cont_w[0][5:0], cont_w[1][5:0], cont_w[2][5:0]};

  always_comb begin
    unique case (need)
      2'd1: begin
        cp_sel = cp1;
        ok     = (cp1 >= CpMin2);
      end
      2'd2: begin
        cp_sel = cp2;
        ok     = (cp2 >= CpMin3) && !((cp2 >= CpSurLo) && (cp2 <= CpSurHi));
      end
      default: begin
        cp_sel = cp3;
        ok     = (cp3 >= CpMin4) && (cp3 <= CpMax);
      end
    endcase
  end

  always_comb begin
    logic       consumed;
    logic [2:0] n;
    result_t [MaxResults-1:0] res;
    dec_state_t nx;
    consumed = 1'b0;
    n        = 3'd0;
    res      = '0;
    nx       = st;

    if (st.pending) begin
      if (is_cont && (need != 2'd0)) begin
        consumed = 1'b1;
        nx.cont  = cont_w;
        nx.count = cont_cnt[1:0];
        if (cont_cnt >= {1'b0, need}) begin
          nx.pending = 1'b0;
          nx.count   = 2'd0;
          if (ok) begin
            res[n[1:0]] = mk_result(cp_sel, 1'b0, {1'b0, need} + 3'd1);
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = mk_error(st.lead);
            n = n + 3'd1;
            for (int i = 0; i < HeldConts; i++) begin
              if (3'(i) < cont_cnt) begin
                res[n[1:0]] = mk_error(cont_w[i]);
                n = n + 3'd1;
              end
            end
          end
        end
      end else begin
        // broken sequence: lead and held continuations go out as errors
        res[n[1:0]] = mk_error(st.lead);
        n = n + 3'd1;
        for (int i = 0; i < HeldConts; i++) begin
          if (2'(i) < st.count) begin
            res[n[1:0]] = mk_error(st.cont[i]);
            n = n + 3'd1;
          end
        end
        nx.pending = 1'b0;
        nx.count   = 2'd0;
      end
    end

    if (!consumed) begin
      priority if (!in_byte[7]) begin
        res[n[1:0]] = mk_result({13'd0, in_byte}, 1'b0, 3'd1);
        n = n + 3'd1;
      end else if (need_cont(in_byte) != 2'd0) begin
        nx.lead    = in_byte;
        nx.count   = 2'd0;
        nx.pending = 1'b1;
      end else begin
        res[n[1:0]] = mk_error(in_byte);
        n = n + 3'd1;
      end
    end

    // end of stream flushes whatever sequence is still open
    if (eos && nx.pending) begin
      res[n[1:0]] = mk_error(nx.lead);
      n = n + 3'd1;
      for (int i = 0; i < HeldConts; i++) begin
        if (2'(i) < nx.count) begin
          res[n[1:0]] = mk_error(nx.cont[i]);
          n = n + 3'd1;
        end
      end
      nx.pending = 1'b0;
      nx.count   = 2'd0;
    end

    dec.nxt = nx;
    dec.res = res;
    dec.n   = n;
  end

endmodule

`default_nettype wire

// ===== test/utf8_stream_decoder_test.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Self-checking bench for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream. Each accepted byte runs through a local
// decoder that keeps its own copy of the open sequence and queues the
// characters and error bytes that the byte must produce. Every result on the
// master stream is checked field by field against the oldest queued entry.
// The run starts with hand-picked sequences for an edge of each form and
// each kind of reject. It then sends random traffic, mostly well-formed
// characters with some broken sequences and noise, under four pacings of
// the two handshakes.
// ----------------------------------------------------------------------------

module utf8_stream_decoder_test;
  import utf8d_pkg::*;

  typedef struct packed {
    result_t res;
    logic    run_end;
    logic    stream_end;
  } decoded_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // in_byte
  logic        s_axis_tlast = 1'b0;    // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // code_point[20:0], bytes_used[23:21]
  logic        m_axis_tlast;           // run_end
  logic [1:0]  m_axis_tuser;           // is_error[0], stream_end[1]

  utf8_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // local copy of the open sequence
  logic [7:0] open_lead = 8'h00;
  logic [7:0] open_conts [3];
  int         open_cnt = 0;
  bit         seq_open = 1'b0;

  decoded_char_t step_chars[$];
  decoded_char_t chars_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int eos_sent = 0;
  int chars_checked = 0;
  int errors_checked = 0;

  function automatic int cont_needed(input logic [7:0] b);
    casez (b)
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      default:     return 0;
    endcase
  endfunction

  function automatic void push_char(input logic [20:0] cp, input logic err,
                                    input logic [2:0] used);
    decoded_char_t c;
    c.res.code_point = cp;
    c.res.is_error   = err;
    c.res.bytes_used = used;
    c.run_end        = 1'b0;
    c.stream_end     = 1'b0;
    step_chars.push_back(c);
  endfunction

  // reject the open sequence byte by byte, lead first
  function automatic void flush_open();
    push_char({13'd0, open_lead}, 1'b1, 3'd1);
    for (int i = 0; i < open_cnt; i++)
      push_char({13'd0, open_conts[i]}, 1'b1, 3'd1);
    seq_open = 1'b0;
    open_cnt = 0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input bit eos);
    int          want;
    bit          taken;
    bit          ok;
    logic [20:0] cp;
    step_chars.delete();
    taken = 1'b0;
    if (seq_open) begin
      want = cont_needed(open_lead);
      if (b[7:6] == 2'b10) begin
        open_conts[open_cnt] = b;
        open_cnt++;
        taken = 1'b1;
        if (open_cnt == want) begin
          case (want)
            1: begin
              cp = {10'd0, open_lead[4:0], open_conts[0][5:0]};
              ok = cp >= CpMin2;
            end
            2: begin
              cp = {5'd0, open_lead[3:0], open_conts[0][5:0], open_conts[1][5:0]};
              ok = cp >= CpMin3 && !(cp >= CpSurLo && cp <= CpSurHi);
            end
            default: begin
              cp = {open_lead[2:0], open_conts[0][5:0], open_conts[1][5:0],
                    open_conts[2][5:0]};
              ok = cp >= CpMin4 && cp <= CpMax;
            end
          endcase
          if (ok) begin
            push_char(cp, 1'b0, 3'(want + 1));
            seq_open = 1'b0;
            open_cnt = 0;
          end else begin
            flush_open();
          end
        end
      end else begin
        flush_open();
      end
    end
    if (!taken) begin
      if (b[7] == 1'b0) begin
        push_char({13'd0, b}, 1'b0, 3'd1);
      end else if (cont_needed(b) != 0) begin
        open_lead = b;
        open_cnt = 0;
        seq_open = 1'b1;
      end else begin
        push_char({13'd0, b}, 1'b1, 3'd1);
      end
    end
    if (eos && seq_open)
      flush_open();
    if (step_chars.size() > 0) begin
      step_chars[step_chars.size() - 1].run_end = 1'b1;
      step_chars[step_chars.size() - 1].stream_end = eos;
    end
    foreach (step_chars[i])
      chars_due.push_back(step_chars[i]);
  endfunction

  // receiver pacing
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    decoded_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (chars_due.size() == 0) begin
        $error("result with nothing awaited: code_point %h", m_axis_tdata[20:0]);
        fail_count++;
      end else begin
        want = chars_due.pop_front();
        chars_checked++;
        if (want.res.is_error)
          errors_checked++;
        if (m_axis_tdata[20:0] !== want.res.code_point) begin
          $error("code_point: expected %h, got %h", want.res.code_point,
                 m_axis_tdata[20:0]);
          fail_count++;
        end
        if (m_axis_tdata[23:21] !== want.res.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.res.bytes_used,
                 m_axis_tdata[23:21]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.res.is_error) begin
          $error("is_error: expected %b, got %b", want.res.is_error, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.stream_end) begin
          $error("stream_end: expected %b, got %b", want.stream_end, m_axis_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eos);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, eos);
    bytes_sent++;
    if (eos)
      eos_sent++;
  endtask

  // hold the sender until every awaited result is out
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_valid_forms();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // smallest two-byte form
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    // largest three-byte form
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // highest code point
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_rejects();
    // stray continuation and byte that never leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // overlong two-byte form
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
    // surrogate
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // beyond the last code point, four errors from one byte
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // sequence broken by an ascii byte, which is then decoded
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    wait_for_results();
  endtask

  task automatic test_end_flush();
    // open sequence flushed by the end flag
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
    wait_for_results();
  endtask

  task automatic run_random(input int n_bytes, input int idle_pct, input int stall_pct);
    logic [7:0]  seq[$];
    logic [7:0]  lead;
    logic [20:0] cp;
    int          first;
    int          kind;
    int          k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      seq.delete();
      kind = $urandom_range(99);
      if (kind < 50) begin
        case ($urandom_range(4, 1))
          1: seq.push_back(8'($urandom_range(8'h7F)));
          2: begin
            cp = 21'($urandom_range(21'h7FF, 21'h80));
            seq.push_back({3'b110, cp[10:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
          3: begin
            cp = 21'($urandom_range(21'hFFFF, 21'h800));
            if (cp >= CpSurLo && cp <= CpSurHi)
              cp[13] = 1'b1;
            seq.push_back({4'b1110, cp[15:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
          default: begin
            cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            seq.push_back({5'b11110, cp[20:18]});
            seq.push_back({2'b10, cp[17:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
        endcase
      end else if (kind < 70) begin
        // any lead with full continuations: overlongs, surrogates, out of range
        lead = 8'($urandom_range(8'hF7, 8'hC0));
        seq.push_back(lead);
        repeat (cont_needed(lead)) seq.push_back({2'b10, 6'($urandom)});
      end else if (kind < 82) begin
        // cut short, then any byte
        lead = 8'($urandom_range(8'hF7, 8'hC2));
        seq.push_back(lead);
        k = $urandom_range(cont_needed(lead) - 1, 0);
        repeat (k) seq.push_back({2'b10, 6'($urandom)});
        seq.push_back(8'($urandom_range(255)));
      end else begin
        seq.push_back(8'($urandom_range(255)));
      end
      foreach (seq[i])
        send_byte(seq[i], $urandom_range(99) < 4);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_valid_forms();
    test_rejects();
    test_end_flush();
    run_random(38, 0, 0);
    run_random(38, 78, 0);
    run_random(38, 0, 78);
    run_random(38, 16, 16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes (%0d flagged end of stream) under four pacings",
             bytes_sent, eos_sent);
    $display("checked %0d results, %0d of them rejected bytes",
             chars_checked, errors_checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $error("timed out with %0d results still awaited", chars_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
